/* sv/gcd_pkg.sv */
// gcd_pkg: shared constants, widths, unit codes and the arctangent table
// for the great-circle distance pipeline. No dependencies.
`default_nettype none
package gcd_pkg;

	// defaults for the top-level parameters
	localparam int CORDIC_STAGES_DEF = 24;
	localparam int ANGLE_FRAC_DEF    = 16;
	localparam int DIST_FRAC_DEF     = 8;

	// fixed field widths
	localparam int COORD_W = 25;
	localparam int UNIT_W  = 2;
	localparam int DIST_W  = 24;

	// internal datapath widths
	localparam int CW      = 34;  // CORDIC x/y and rotation angle, Q30
	localparam int ZW      = 36;  // vectoring angle accumulator, Q30
	localparam int ROOT_W  = 31;  // sqrt(2^60 - c^2) <= 2^30
	localparam int RAD_W   = 62;  // radicand

	// fixed-point constants
	localparam longint Q30_ONE           = 64'd1 << 30;
	localparam longint DEG_TO_RAD_Q32    = 74961321;
	localparam longint RAD_TO_DEG_Q24    = 961263669;
	localparam longint MILES_PER_DEG_Q16 = 4527882;
	localparam longint CORDIC_SEED_Q30   = 652032874;
	localparam longint HALF_PI_Q30       = 1686629713;
	localparam longint KM_FACTOR_Q24     = 27000312;
	localparam longint NM_FACTOR_Q24     = 14569334;
	localparam longint ONE_Q24           = 16777216;

	typedef enum logic [UNIT_W-1:0] {
		UNIT_MILES = 2'd0,
		UNIT_KM    = 2'd1,
		UNIT_NM    = 2'd2,
		UNIT_ALT   = 2'd3
	} unit_t;

	// atan(2^-i) in Q30
	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'd843314857;
			1:  r = 32'd497837829;
			2:  r = 32'd263043837;
			3:  r = 32'd133525159;
			4:  r = 32'd67021687;
			5:  r = 32'd33543516;
			6:  r = 32'd16775851;
			7:  r = 32'd8388437;
			8:  r = 32'd4194283;
			9:  r = 32'd2097149;
			10: r = 32'd1048576;
			default: r = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* sv/gcd_rot.sv */
// gcd_rot: three-lane pipelined CORDIC in rotation mode, one stage per
// iteration; gives cos and sin in Q30. Depends on gcd_pkg.
`default_nettype none
module gcd_rot #(
	parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF,
	parameter int SB_W   = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic signed [gcd_pkg::CW-1:0] in_z [3],
	input  wire logic [SB_W-1:0]               in_sb,
	output logic                                out_valid,
	output logic signed [gcd_pkg::CW-1:0]      out_x [3],
	output logic signed [gcd_pkg::CW-1:0]      out_y [3],
	output logic [SB_W-1:0]                    out_sb
);
	import gcd_pkg::*;

	logic signed [CW-1:0] x_s [0:STAGES][0:2];
	logic signed [CW-1:0] y_s [0:STAGES][0:2];
	logic signed [CW-1:0] z_s [0:STAGES][0:2];
	logic                 v_s [0:STAGES];
	logic [SB_W-1:0]      sb_s [0:STAGES];

	assign v_s[0]  = in_valid;
	assign sb_s[0] = in_sb;
	for (genvar l = 0; l < 3; l++) begin : g_seed
		assign x_s[0][l] = CW'(CORDIC_SEED_Q30);
		assign y_s[0][l] = '0;
		assign z_s[0][l] = in_z[l];
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_st
		localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(g));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[g+1] <= sb_s[g];
				for (int l = 0; l < 3; l++) begin
					if (z_s[g][l] >= 0) begin
						x_s[g+1][l] <= x_s[g][l] - (y_s[g][l] >>> g);
						y_s[g+1][l] <= y_s[g][l] + (x_s[g][l] >>> g);
						z_s[g+1][l] <= z_s[g][l] - ATAN;
					end else begin
						x_s[g+1][l] <= x_s[g][l] + (y_s[g][l] >>> g);
						y_s[g+1][l] <= y_s[g][l] - (x_s[g][l] >>> g);
						z_s[g+1][l] <= z_s[g][l] + ATAN;
					end
				end
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_sb    = sb_s[STAGES];
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_x[l] = x_s[STAGES][l];
		assign out_y[l] = y_s[STAGES][l];
	end

endmodule
`default_nettype wire

/* sv/gcd_isqrt.sv */
// gcd_isqrt: pipelined digit-by-digit integer square root, one result bit
// per stage. Depends on gcd_pkg.
`default_nettype none
module gcd_isqrt #(
	parameter int SB_W = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [gcd_pkg::RAD_W-1:0]    in_n,
	input  wire logic [SB_W-1:0]              in_sb,
	output logic                               out_valid,
	output logic [gcd_pkg::ROOT_W-1:0]        out_root,
	output logic [SB_W-1:0]                   out_sb
);
	import gcd_pkg::*;

	logic [RAD_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic              v_s    [0:ROOT_W];
	logic [SB_W-1:0]   sb_s   [0:ROOT_W];

	assign rem_s[0]  = in_n;
	assign root_s[0] = '0;
	assign v_s[0]    = in_valid;
	assign sb_s[0]   = in_sb;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_st
		localparam int B = ROOT_W - 1 - g;
		logic [RAD_W-1:0] cand;

		// (2*root + 2^B) * 2^B
		assign cand = (RAD_W'(root_s[g]) << (B + 1)) + (RAD_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[g+1] <= sb_s[g];
				if (rem_s[g] >= cand) begin
					rem_s[g+1]  <= rem_s[g] - cand;
					root_s[g+1] <= root_s[g] | (ROOT_W'(1) << B);
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g];
				end
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_sb    = sb_s[ROOT_W];

endmodule
`default_nettype wire

/* sv/gcd_vec.sv */
// gcd_vec: pipelined CORDIC in vectoring mode; accumulates the angle of
// (x, y) onto pi/2 to form acos. Depends on gcd_pkg.
`default_nettype none
module gcd_vec #(
	parameter int STAGES = gcd_pkg::CORDIC_STAGES_DEF,
	parameter int SB_W   = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic signed [gcd_pkg::CW-1:0] in_x,
	input  wire logic signed [gcd_pkg::CW-1:0] in_y,
	input  wire logic [SB_W-1:0]               in_sb,
	output logic                                out_valid,
	output logic signed [gcd_pkg::ZW-1:0]      out_z,
	output logic [SB_W-1:0]                    out_sb
);
	import gcd_pkg::*;

	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [ZW-1:0] z_s [0:STAGES];
	logic                 v_s [0:STAGES];
	logic [SB_W-1:0]      sb_s [0:STAGES];

	assign x_s[0]  = in_x;
	assign y_s[0]  = in_y;
	assign z_s[0]  = ZW'(HALF_PI_Q30);
	assign v_s[0]  = in_valid;
	assign sb_s[0] = in_sb;

	for (genvar g = 0; g < STAGES; g++) begin : g_st
		localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(g));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[g+1] <= sb_s[g];
				if (y_s[g] >= 0) begin
					x_s[g+1] <= x_s[g] + (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] - (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] + ATAN;
				end else begin
					x_s[g+1] <= x_s[g] - (y_s[g] >>> g);
					y_s[g+1] <= y_s[g] + (x_s[g] >>> g);
					z_s[g+1] <= z_s[g] - ATAN;
				end
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign out_z     = z_s[STAGES];
	assign out_sb    = sb_s[STAGES];

endmodule
`default_nettype wire

/* sv/great_circle_distance.sv */
// great_circle_distance: top level of the spherical law of cosines distance
// pipeline. Depends on gcd_pkg, gcd_rot, gcd_isqrt and gcd_vec.
//
// Takes two positions (latitude, longitude in signed degrees with
// ANGLE_FRACTION_BITS fraction bits) and a unit code per item and returns
// one distance per item, unsigned with DISTANCE_FRACTION_BITS fraction bits,
// saturating at all ones. A coordinate outside +-90 (latitude) or +-180
// (longitude) gives invalid=1 and a zero distance. The block is a single
// stall-together pipeline: one item can enter every cycle unless the output waits, and the whole
// pipeline, output register included, holds while the output waits.
// In order, the pipeline does the range check and radians, sin/cos, the
// products, clamp and radicand, the square root, acos, and unit scaling
// and rounding. No state survives between items.
`default_nettype none
module great_circle_distance #(
	parameter int CORDIC_STAGES          = gcd_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_FRACTION_BITS    = gcd_pkg::ANGLE_FRAC_DEF,
	parameter int DISTANCE_FRACTION_BITS = gcd_pkg::DIST_FRAC_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// first_latitude, first_longitude, second_latitude, second_longitude,
	// 25 bits each, then 4 zero bits
	input  wire logic [103:0]  s_tdata,
	// unit_code
	input  wire logic [1:0]    s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// distance_out
	output logic [23:0]        m_tdata,
	// invalid
	output logic [0:0]         m_tuser
);
	import gcd_pkg::*;

	localparam int TW = 36;  // range-check / fold width
	localparam logic signed [TW-1:0] DEG90  = TW'(90)  << ANGLE_FRACTION_BITS;
	localparam logic signed [TW-1:0] DEG180 = TW'(180) << ANGLE_FRACTION_BITS;
	localparam logic signed [TW-1:0] DEG360 = TW'(360) << ANGLE_FRACTION_BITS;
	localparam logic signed [27:0]   D2R    = 28'(DEG_TO_RAD_Q32);
	localparam logic signed [CW-1:0] C_ONE  = CW'(Q30_ONE);
	localparam int SH = 48 - DISTANCE_FRACTION_BITS;

	// global advance: everything moves when the output slot is free
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: range check and longitude difference fold ----
	logic signed [TW-1:0] la1, lo1, la2, lo2, td, ta, tb;
	logic                 bad, fold_neg;
	logic signed [TW-1:0] tfin;

	always_comb begin
		la1 = TW'(signed'(s_tdata[24:0]));
		lo1 = TW'(signed'(s_tdata[49:25]));
		la2 = TW'(signed'(s_tdata[74:50]));
		lo2 = TW'(signed'(s_tdata[99:75]));
		bad = la1 > DEG90 || la1 < -DEG90 || la2 > DEG90 || la2 < -DEG90 ||
		      lo1 > DEG180 || lo1 < -DEG180 || lo2 > DEG180 || lo2 < -DEG180;
		td  = lo1 - lo2;
		ta  = (td < 0) ? -td : td;
		tb  = (ta > DEG180) ? DEG360 - ta : ta;
		// cos(180 - t) = -cos(t)
		fold_neg = tb > DEG90;
		tfin = fold_neg ? DEG180 - tb : tb;
	end

	logic                     v_s1, neg_s1, inv_s1;
	logic signed [COORD_W-1:0] la1_s1, la2_s1;
	logic signed [COORD_W:0]  t_s1;
	logic [UNIT_W-1:0]        unit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			la1_s1  <= s_tdata[24:0];
			la2_s1  <= s_tdata[74:50];
			t_s1    <= (COORD_W+1)'(tfin);
			neg_s1  <= fold_neg;
			inv_s1  <= bad;
			unit_s1 <= s_tuser;
		end
	end

	// ---- stage 2: degrees to radians (Q30) ----
	logic signed [52:0] pr1, pr2;
	logic signed [53:0] prt;
	assign pr1 = la1_s1 * D2R;
	assign pr2 = la2_s1 * D2R;
	assign prt = t_s1 * D2R;

	logic                 v_s2;
	logic signed [CW-1:0] z_s2 [3];
	logic [3:0]           sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2[0] <= CW'(pr1 >>> (ANGLE_FRACTION_BITS + 2));
			z_s2[1] <= CW'(pr2 >>> (ANGLE_FRACTION_BITS + 2));
			z_s2[2] <= CW'(prt >>> (ANGLE_FRACTION_BITS + 2));
			sb_s2   <= {unit_s1, inv_s1, neg_s1};
		end
	end

	// ---- sin/cos of both latitudes and the longitude difference ----
	logic                 rot_v;
	logic signed [CW-1:0] rot_x [3];
	logic signed [CW-1:0] rot_y [3];
	logic [3:0]           rot_sb;

	gcd_rot #(
		.STAGES (CORDIC_STAGES),
		.SB_W   (4)
	) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_z      (z_s2),
		.in_sb     (sb_s2),
		.out_valid (rot_v),
		.out_x     (rot_x),
		.out_y     (rot_y),
		.out_sb    (rot_sb)
	);

	// ---- stage 3: s1*s2 and c1*c2 ----
	logic signed [2*CW-1:0] pss, pcc;
	assign pss = rot_y[0] * rot_y[1];
	assign pcc = rot_x[0] * rot_x[1];

	logic                 v_s3;
	logic signed [CW-1:0] p1_s3, p2_s3, cd_s3;
	logic [2:0]           sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= rot_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3 <= CW'(pss >>> 30);
			p2_s3 <= CW'(pcc >>> 30);
			cd_s3 <= rot_sb[0] ? -rot_x[2] : rot_x[2];
			sb_s3 <= rot_sb[3:1];
		end
	end

	// ---- stage 4: c1*c2*cos(dlon) ----
	logic signed [2*CW-1:0] pccd;
	assign pccd = p2_s3 * cd_s3;

	logic                 v_s4;
	logic signed [CW-1:0] p1_s4, p3_s4;
	logic [2:0]           sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s4 <= p1_s3;
			p3_s4 <= CW'(pccd >>> 30);
			sb_s4 <= sb_s3;
		end
	end

	// ---- stage 5: cosine sum, clamped to [-1, 1] ----
	logic signed [CW:0] csum;
	assign csum = (CW+1)'(p1_s4) + (CW+1)'(p3_s4);

	logic                 v_s5;
	logic signed [CW-1:0] c_s5;
	logic [2:0]           sb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (csum > (CW+1)'(C_ONE)) begin
				c_s5 <= C_ONE;
			end else if (csum < -(CW+1)'(C_ONE)) begin
				c_s5 <= -C_ONE;
			end else begin
				c_s5 <= CW'(csum);
			end
			sb_s5 <= sb_s4;
		end
	end

	// ---- stage 6: radicand 2^60 - c^2 ----
	logic signed [2*CW-1:0] csq;
	assign csq = c_s5 * c_s5;

	logic              v_s6;
	logic [RAD_W-1:0]  n_s6;
	logic [CW+2:0]     sb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6  <= (RAD_W'(1) << 60) - RAD_W'(csq);
			sb_s6 <= {c_s5, sb_s5};
		end
	end

	// ---- square root, c travels alongside ----
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	logic [CW+2:0]     sq_sb;

	gcd_isqrt #(
		.SB_W (CW + 3)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_n      (n_s6),
		.in_sb     (sb_s6),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	// ---- acos as pi/2 + angle of (sqrt(1-c^2), -c) ----
	logic signed [CW-1:0] vx, vy, c_sq;
	assign c_sq = sq_sb[CW+2:3];
	assign vx   = CW'(sq_root);
	assign vy   = -c_sq;

	logic                 ac_v;
	logic signed [ZW-1:0] ac_z;
	logic [2:0]           ac_sb;

	gcd_vec #(
		.STAGES (CORDIC_STAGES),
		.SB_W   (3)
	) u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.in_x      (vx),
		.in_y      (vy),
		.in_sb     (sq_sb[2:0]),
		.out_valid (ac_v),
		.out_z     (ac_z),
		.out_sb    (ac_sb)
	);

	// ---- stage 7: arc (negative forced to zero) to degrees Q24 ----
	logic [32:0] arc;
	logic [62:0] pdeg;
	assign arc  = (ac_z < 0) ? '0 : 33'(ac_z);
	assign pdeg = arc * 30'(RAD_TO_DEG_Q24);

	logic        v_s7;
	logic [32:0] deg_s7;
	logic [2:0]  sb_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= ac_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s7 <= 33'(pdeg >> 30);
			sb_s7  <= ac_sb;
		end
	end

	// ---- stage 8: degrees to statute miles Q24 ----
	logic [55:0] pmil;
	assign pmil = deg_s7 * 23'(MILES_PER_DEG_Q16);

	logic        v_s8;
	logic [39:0] mil_s8;
	logic [2:0]  sb_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mil_s8 <= 40'(pmil >> 16);
			sb_s8  <= sb_s7;
		end
	end

	// ---- stage 9: unit factor, round half up, saturate, zero when invalid ----
	unit_t       unit_s8;
	logic [24:0] factor;
	logic [65:0] pdist, dist_full;

	assign unit_s8 = unit_t'(sb_s8[2:1]);

	always_comb begin
		unique case (unit_s8)
			UNIT_KM: factor = 25'(KM_FACTOR_Q24);
			UNIT_NM: factor = 25'(NM_FACTOR_Q24);
			default: factor = 25'(ONE_Q24);
		endcase
	end

	assign pdist     = mil_s8 * factor;
	assign dist_full = (pdist + (66'(1) << (SH - 1))) >> SH;

	logic               v_s9;
	logic [DIST_W-1:0]  dist_s9;
	logic               inv_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s9 <= sb_s8[0];
			if (sb_s8[0]) begin
				dist_s9 <= '0;
			end else if ((dist_full >> DIST_W) != '0) begin
				dist_s9 <= '1;
			end else begin
				dist_s9 <= DIST_W'(dist_full);
			end
		end
	end

	assign m_tvalid   = v_s9;
	assign m_tdata    = dist_s9;
	assign m_tuser[0] = inv_s9;

	// ---- checks ----
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("invalid item with nonzero distance");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v |-> sq_root <= (ROOT_W'(1) << 30))
		else $error("square root above one");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> n_s6 <= (RAD_W'(1) << 60))
		else $error("radicand above one");

endmodule
`default_nettype wire
